// ----- rtl/core/pasrd_pkg.sv -----
package pasrd_pkg;

  localparam int unsigned AngleW  = 9;
  localparam int unsigned TableW  = 8;
  localparam int unsigned ReloadW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_LEVEL   = 2'd1,
    REQ_RESTART = 2'd2
  } req_kind_t;

  localparam logic [CfgIdxW-1:0] REG_ANGLE_HIGH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_MID   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_LOW   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_START = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_UNIT_TIME   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TIMER_TOP   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_TICK_MS     = 3'd6;

  localparam logic [1:0] LEVEL_START = 2'd3;

  localparam logic [TableW-1:0] RST_ANGLE_HIGH  = 8'd140;
  localparam logic [TableW-1:0] RST_ANGLE_MID   = 8'd90;
  localparam logic [TableW-1:0] RST_ANGLE_LOW   = 8'd10;
  localparam logic [TableW-1:0] RST_ANGLE_START = 8'd170;
  localparam logic [7:0]        RST_UNIT_TIME   = 8'd55;
  localparam logic [15:0]       RST_TIMER_TOP   = 16'hFFFF;
  localparam logic [3:0]        RST_TICK_MS     = 4'd1;

  localparam logic [7:0]        UPDATE_MARK = 8'd10;
  localparam logic [TableW-1:0] DITHER_STEP = 8'd5;

  typedef struct packed {
    logic [3:0][TableW-1:0] angle_tbl;
    logic [7:0]             unit_time;
    logic [15:0]            timer_top;
    logic [3:0]             tick_ms;
  } cfg_t;

  typedef struct packed {
    logic               reload_valid;
    logic [ReloadW-1:0] reload_value;
    logic [AngleW-1:0]  current_angle;
    logic [1:0]         target_level;
    logic               stable;
  } result_t;

endpackage

// ----- rtl/core/pasrd_cfg.sv -----
module pasrd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pasrd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pasrd_pkg::CfgDataW-1:0]  cfg_data,
  output pasrd_pkg::cfg_t                 cfg
);

  pasrd_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.angle_tbl[0] <= pasrd_pkg::RST_ANGLE_HIGH;
      regs.angle_tbl[1] <= pasrd_pkg::RST_ANGLE_MID;
      regs.angle_tbl[2] <= pasrd_pkg::RST_ANGLE_LOW;
      regs.angle_tbl[3] <= pasrd_pkg::RST_ANGLE_START;
      regs.unit_time    <= pasrd_pkg::RST_UNIT_TIME;
      regs.timer_top    <= pasrd_pkg::RST_TIMER_TOP;
      regs.tick_ms      <= pasrd_pkg::RST_TICK_MS;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        pasrd_pkg::REG_ANGLE_HIGH, pasrd_pkg::REG_ANGLE_MID,
        pasrd_pkg::REG_ANGLE_LOW, pasrd_pkg::REG_ANGLE_START: begin
          regs.angle_tbl[cfg_index[1:0]] <= cfg_data[pasrd_pkg::TableW-1:0];
        end
        pasrd_pkg::REG_UNIT_TIME: regs.unit_time <= cfg_data[7:0];
        pasrd_pkg::REG_TIMER_TOP: regs.timer_top <= cfg_data[15:0];
        pasrd_pkg::REG_TICK_MS:   regs.tick_ms   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- rtl/core/pasrd_track.sv -----
module pasrd_track (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [1:0]            req_type,
  input  logic [1:0]            level,
  input  pasrd_pkg::cfg_t       cfg,
  output pasrd_pkg::result_t    result
);

  localparam int unsigned AW = pasrd_pkg::AngleW;
  localparam int unsigned TW = pasrd_pkg::TableW;

  logic [7:0]    tick_accum, tick_accum_next;
  logic [2:0]    ramp_phase, ramp_phase_next;
  logic          dither_phase, dither_phase_next;
  logic          dither_side_high, dither_side_high_next;
  logic [AW-1:0] angle_now, angle_now_next;
  logic [TW-1:0] angle_goal, angle_goal_next;
  logic [1:0]    goal_index, goal_index_next;
  logic          settled, settled_next;

  logic [7:0]    acc_sum;
  logic          update;
  logic [16:0]   product;
  logic [15:0]   reload;
  logic [AW-1:0] goal_ext;
  logic [AW-1:0] ramp_angle;
  logic          ramp_settled;

  assign acc_sum  = tick_accum + {4'd0, cfg.tick_ms};
  assign update   = (req_type == pasrd_pkg::REQ_TICK) && (acc_sum == pasrd_pkg::UPDATE_MARK);
  assign product  = angle_now * cfg.unit_time;
  assign reload   = cfg.timer_top - product[15:0];
  assign goal_ext = {1'b0, angle_goal};

  always_comb begin
    tick_accum_next       = tick_accum;
    ramp_phase_next       = ramp_phase;
    dither_phase_next     = dither_phase;
    dither_side_high_next = dither_side_high;
    angle_now_next        = angle_now;
    angle_goal_next       = angle_goal;
    goal_index_next       = goal_index;
    settled_next          = settled;
    ramp_angle            = angle_now;
    ramp_settled          = settled;

    case (req_type)
      pasrd_pkg::REQ_TICK: begin
        tick_accum_next = update ? 8'd0 : acc_sum;
        if (update) begin
          ramp_phase_next = ramp_phase + 3'd1;
          // step toward the goal once every eight updates
          if (ramp_phase_next == 3'd0) begin
            if (!settled && angle_now < goal_ext) begin
              ramp_angle = angle_now + 9'd1;
            end else if (!settled && angle_now > goal_ext) begin
              ramp_angle = angle_now - 9'd1;
            end else begin
              ramp_settled = 1'b1;
            end
          end
          angle_now_next    = ramp_angle;
          settled_next      = ramp_settled;
          dither_phase_next = ~dither_phase;
          // alternate low and high dither around a settled goal
          if (dither_phase && ramp_settled) begin
            if (dither_side_high) begin
              angle_now_next        = goal_ext + {1'b0, pasrd_pkg::DITHER_STEP};
              dither_side_high_next = 1'b0;
            end else begin
              angle_now_next = (angle_goal >= pasrd_pkg::DITHER_STEP) ?
                               {1'b0, angle_goal - pasrd_pkg::DITHER_STEP} : '0;
              dither_side_high_next = 1'b1;
            end
          end
        end
      end
      pasrd_pkg::REQ_LEVEL: begin
        goal_index_next = level;
        angle_goal_next = cfg.angle_tbl[level];
        settled_next    = 1'b0;
      end
      pasrd_pkg::REQ_RESTART: begin
        goal_index_next = pasrd_pkg::LEVEL_START;
        angle_goal_next = cfg.angle_tbl[pasrd_pkg::LEVEL_START];
        angle_now_next  = {1'b0, cfg.angle_tbl[pasrd_pkg::LEVEL_START]};
        settled_next    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_accum       <= '0;
      ramp_phase       <= '0;
      dither_phase     <= 1'b0;
      dither_side_high <= 1'b0;
      angle_now        <= {1'b0, pasrd_pkg::RST_ANGLE_START};
      angle_goal       <= pasrd_pkg::RST_ANGLE_START;
      goal_index       <= pasrd_pkg::LEVEL_START;
      settled          <= 1'b1;
    end else if (step) begin
      tick_accum       <= tick_accum_next;
      ramp_phase       <= ramp_phase_next;
      dither_phase     <= dither_phase_next;
      dither_side_high <= dither_side_high_next;
      angle_now        <= angle_now_next;
      angle_goal       <= angle_goal_next;
      goal_index       <= goal_index_next;
      settled          <= settled_next;
    end
  end

  assign result.reload_valid  = update;
  assign result.reload_value  = update ? reload : '0;
  assign result.current_angle = angle_now_next;
  assign result.target_level  = goal_index_next;
  assign result.stable        = settled_next;

endmodule

// ----- rtl/core/phase_angle_soft_ramp_dither.sv -----
// Triac firing-angle tracker with soft start and dither.
// Request channel: req_valid/req_stall carry req_type (tick, level request,
// restart) and level. Response channel: rsp_valid/rsp_stall carry one result
// item per request: reload_valid, reload_value, current_angle, target_level
// and stable.
// Configuration: write cfg_data into register cfg_index while cfg_we is high,
// only while the block is idle. Indexes 0..3 are the angle table, 4 the
// timer counts per angle step, 5 the timer top, 6 the tick size.
// A request is accepted into one input register, then the state update and
// reload multiply-subtract run, whose result lands in the output register.
// One item is accepted every cycle while req_stall is low.
// When the receiver stalls, the output register holds its item and the input
// register takes one more; req_stall rises only when both are full.
// Synchronous reset empties both registers and loads the reset angle table,
// the start angle as current and target angle, and sets stable.
module phase_angle_soft_ramp_dither (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [1:0]                     req_type,
  input  logic [1:0]                     level,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           reload_valid,
  output logic [pasrd_pkg::ReloadW-1:0]  reload_value,
  output logic [pasrd_pkg::AngleW-1:0]   current_angle,
  output logic [1:0]                     target_level,
  output logic                           stable,
  input  logic                           cfg_we,
  input  logic [pasrd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pasrd_pkg::CfgDataW-1:0] cfg_data
);

  pasrd_pkg::cfg_t    cfg;
  pasrd_pkg::result_t result;
  pasrd_pkg::result_t rsp;

  logic       s1_valid;
  logic [1:0] s1_type;
  logic [1:0] s1_level;
  logic       s1_move;
  logic       accept;

  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  pasrd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pasrd_track u_track (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_move),
    .req_type (s1_type),
    .level    (s1_level),
    .cfg      (cfg),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type  <= req_type;
      s1_level <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp <= result;
    end
  end

  assign reload_valid  = rsp.reload_valid;
  assign reload_value  = rsp.reload_value;
  assign current_angle = rsp.current_angle;
  assign target_level  = rsp.target_level;
  assign stable        = rsp.stable;

endmodule
